// ===== design/c3sb_pkg.sv =====
// Package: shared types and constants for the 3x3 border/scale/bias filter.
`default_nettype none
package c3sb_pkg;

    localparam int C3SB_MAX_WIDTH = 1024;

    localparam int unsigned REG_IMAGE_WIDTH  = 0;
    localparam int unsigned REG_IMAGE_HEIGHT = 1;
    localparam int unsigned REG_BORDER_REP   = 2;
    localparam int unsigned REG_ABS_RESP     = 3;
    localparam int unsigned REG_SCALE        = 4;
    localparam int unsigned REG_BIAS         = 5;
    localparam int unsigned REG_KERNEL_UP    = 6;
    localparam int unsigned REG_KERNEL_LO    = 7;

    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd768;
    localparam logic [23:0] RST_SCALE        = 24'd65536;
    localparam logic [47:0] RST_KERNEL_UP    = 48'h0001_0000_0000;

    typedef logic [7:0]         pix_t;
    typedef logic signed [7:0]  coef_t;
    typedef logic signed [17:0] psum_t;

    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } col_t;

    typedef struct packed {
        logic shift;
        logic calc;
        logic top_bad;
        logic bot_bad;
        logic replicate;
    } cell_ctl_t;

endpackage
`default_nettype wire

// ===== design/conv3x3_border_scale_bias_top.sv =====
// Top level: 3x3 convolution over a raster pixel stream with border, scale and bias.
//
// Usage:
//  Input channel in_valid/in_ready carries cmd (0 pixel, 1 drain tick) and
//  pixel_in in raster order. Output channel out_valid/out_ready carries
//  pixel_out and frame_last. Registers are written through cfg_valid/cfg_ready
//  with cfg_index and cfg_data; the user must write them only while the block is
//  idle, which the block itself does not enforce. cfg_ready is always high.
//  Each item passes a line-store read, a shift of the three window cells,
//  the per-column sums, the scale multiply and the bias/round stage, in that
//  fixed sequence of states; a new item is taken only once the last is idle.
//  A result reaches out_valid after ST_RD, ST_WIN, ST_MUL and ST_FIN; ST_FIN waits while the output is stalled.
//  The output for pixel (x,y) comes with input (x+1,y+1); after a frame,
//  width+1 drain ticks flush the rest. Items that produce no result return
//  to idle without touching the output.
//  While the receiver stalls, a finished result waits in the output register
//  and the next item is still taken and processed up to the final stage.
//  Reset clears position counters, window and registers to their defaults;
//  the line store is not cleared.
`default_nettype none
module conv3x3_border_scale_bias_top
    import c3sb_pkg::*;
#(
    parameter int MAX_WIDTH = C3SB_MAX_WIDTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        cmd,
    input  wire logic [7:0]  pixel_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       pixel_out,
    output logic             frame_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_WIN, ST_MUL, ST_FIN} state_t;

    state_t state_reg;

    logic [10:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic        border_rep_reg;
    logic        abs_resp_reg;
    logic [23:0] scale_reg;
    logic [16:0] bias_reg;
    logic [47:0] kernel_up_reg;
    logic [23:0] kernel_lo_reg;

    logic [WW-1:0] in_col_reg;
    logic [16:0]   in_row_reg;
    logic [WW-1:0] in_col_next;
    logic [16:0]   in_row_next;

    logic [WW-1:0] w_eff;
    logic [16:0]   h_eff;
    logic          wrap;
    logic [WW-1:0] c_a;
    logic [16:0]   r_a;
    logic          restart;
    logic [WW-1:0] c_cur;
    logic [16:0]   r_cur;
    logic [WW-1:0] ox_cur;
    logic [16:0]   oy_cur;
    logic          vld_cur;
    logic          last_cur;

    logic [AW-1:0] addr_reg;
    logic [WW-1:0] ox_reg;
    logic [16:0]   oy_reg;
    logic          vld_reg;
    logic          last_reg;
    pix_t          px_reg;

    logic [15:0]   mem [MAX_WIDTH];
    logic [15:0]   rd_reg;

    coef_t         coefs [9];
    cell_ctl_t     ctl;
    col_t          d2;
    col_t          q0;
    col_t          q1;
    col_t          q2;
    psum_t         ps0;
    psum_t         ps1;
    psum_t         ps2;
    logic          left_bad;
    logic          right_bad;

    logic signed [19:0] s_sum;
    logic signed [43:0] prod_reg;
    logic signed [44:0] mag;
    logic signed [45:0] v_acc;
    logic [29:0]        q_round;
    pix_t               res_px;

    logic          out_valid_reg;
    pix_t          pixel_out_reg;
    logic          frame_last_reg;
    logic          accept;
    logic          fin_go;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);

    // effective frame size
    always_comb
    begin
        if ({21'd0, image_width_reg} > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(image_width_reg);
        end
        if (w_eff == '0)
        begin
            w_eff = WW'(1);
        end
        h_eff = (image_height_reg == '0) ? 17'd1 : {1'b0, image_height_reg};
    end

    // input position and output coordinate for the item at the port
    always_comb
    begin
        wrap    = (in_col_reg >= w_eff);
        c_a     = wrap ? '0 : in_col_reg;
        r_a     = wrap ? (in_row_reg + 17'd1) : in_row_reg;
        restart = ({1'b0, r_a} > ({1'b0, h_eff} + 18'd1));
        c_cur   = restart ? '0 : c_a;
        r_cur   = restart ? '0 : r_a;
        if (c_cur != '0)
        begin
            ox_cur  = c_cur - WW'(1);
            vld_cur = (r_cur >= 17'd1);
            oy_cur  = vld_cur ? (r_cur - 17'd1) : '0;
        end
        else
        begin
            ox_cur  = w_eff - WW'(1);
            vld_cur = (r_cur >= 17'd2);
            oy_cur  = vld_cur ? (r_cur - 17'd2) : '0;
        end
        if (vld_cur && (oy_cur >= h_eff))
        begin
            vld_cur = 1'b0;
        end
        last_cur = vld_cur && (ox_cur == (w_eff - WW'(1))) && (oy_cur == (h_eff - 17'd1));
        if (last_cur)
        begin
            in_col_next = '0;
            in_row_next = '0;
        end
        else if (({1'b0, c_cur} + {{WW{1'b0}}, 1'b1}) >= {1'b0, w_eff})
        begin
            in_col_next = '0;
            in_row_next = r_cur + 17'd1;
        end
        else
        begin
            in_col_next = c_cur + WW'(1);
            in_row_next = r_cur;
        end
    end

    // configuration and position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            border_rep_reg   <= 1'b0;
            abs_resp_reg     <= 1'b0;
            scale_reg        <= RST_SCALE;
            bias_reg         <= '0;
            kernel_up_reg    <= RST_KERNEL_UP;
            kernel_lo_reg    <= '0;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (32'(cfg_index))
                    REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[10:0];
                    REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[15:0];
                    REG_BORDER_REP:   border_rep_reg   <= cfg_data[0];
                    REG_ABS_RESP:     abs_resp_reg     <= cfg_data[0];
                    REG_SCALE:        scale_reg        <= cfg_data[23:0];
                    REG_BIAS:         bias_reg         <= cfg_data[16:0];
                    REG_KERNEL_UP:    kernel_up_reg    <= cfg_data;
                    REG_KERNEL_LO:    kernel_lo_reg    <= cfg_data[23:0];
                    default:          ;
                endcase
            end
            if (accept)
            begin
                in_col_reg <= in_col_next;
                in_row_reg <= in_row_next;
            end
        end
    end

    // per-item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= c_cur[AW-1:0];
            ox_reg   <= ox_cur;
            oy_reg   <= oy_cur;
            vld_reg  <= vld_cur;
            last_reg <= last_cur;
            px_reg   <= cmd ? '0 : pixel_in;
        end
    end

    // line store: low byte row above, high byte two rows above
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg <= mem[c_cur[AW-1:0]];
        end
        if (state_reg == ST_RD)
        begin
            mem[addr_reg] <= {rd_reg[7:0], px_reg};
        end
    end

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            if (i < 6)
            begin
                coefs[i] = kernel_up_reg[8*i +: 8];
            end
            else
            begin
                coefs[i] = kernel_lo_reg[8*(i-6) +: 8];
            end
        end
    end

    assign left_bad  = (ox_reg == '0);
    assign right_bad = (({1'b0, ox_reg} + {{WW{1'b0}}, 1'b1}) >= {1'b0, w_eff});

    always_comb
    begin
        ctl.shift     = (state_reg == ST_RD);
        ctl.calc      = (state_reg == ST_WIN);
        ctl.top_bad   = (oy_reg == '0);
        ctl.bot_bad   = ((oy_reg + 17'd1) >= h_eff);
        ctl.replicate = border_rep_reg;
        d2.top        = rd_reg[15:8];
        d2.mid        = rd_reg[7:0];
        d2.bot        = px_reg;
    end

    c3sb_cell u_cell0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .col_bad  (left_bad),
        .d_in     (q1),
        .alt      (q1),
        .coef_top (coefs[0]),
        .coef_mid (coefs[3]),
        .coef_bot (coefs[6]),
        .q_out    (q0),
        .psum     (ps0)
    );

    c3sb_cell u_cell1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .col_bad  (1'b0),
        .d_in     (q2),
        .alt      (q1),
        .coef_top (coefs[1]),
        .coef_mid (coefs[4]),
        .coef_bot (coefs[7]),
        .q_out    (q1),
        .psum     (ps1)
    );

    c3sb_cell u_cell2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .col_bad  (right_bad),
        .d_in     (d2),
        .alt      (q1),
        .coef_top (coefs[2]),
        .coef_mid (coefs[5]),
        .coef_bot (coefs[8]),
        .q_out    (q2),
        .psum     (ps2)
    );

    assign s_sum = 20'(ps0) + 20'(ps1) + 20'(ps2);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_reg <= 44'(s_sum * $signed(scale_reg));
        end
    end

    // absolute value, bias, round half away from zero, saturate
    always_comb
    begin
        if (abs_resp_reg && prod_reg[43])
        begin
            mag = -45'(prod_reg);
        end
        else
        begin
            mag = 45'(prod_reg);
        end
        v_acc   = 46'(mag) + 46'($signed({bias_reg, 8'd0}));
        q_round = 30'((v_acc + 46'sd32768) >>> 16);
        if (v_acc <= 46'sd0)
        begin
            res_px = '0;
        end
        else if (q_round > 30'd255)
        begin
            res_px = 8'd255;
        end
        else
        begin
            res_px = q_round[7:0];
        end
    end

    assign fin_go = !vld_reg || !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            pixel_out_reg  <= '0;
            frame_last_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_FIN) && fin_go && vld_reg)
            begin
                out_valid_reg  <= 1'b1;
                pixel_out_reg  <= res_px;
                frame_last_reg <= last_reg;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_RD;
                    end
                end
                ST_RD:  state_reg <= ST_WIN;
                ST_WIN: state_reg <= ST_MUL;
                ST_MUL: state_reg <= ST_FIN;
                ST_FIN:
                begin
                    if (fin_go)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign frame_last = frame_last_reg;

`ifndef SYNTHESIS
    a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RD))
        else $error("accepted item did not start a line-store read");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input taken while an item is in flight");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && vld_reg && out_valid_reg && !out_ready)
        |=> ((state_reg == ST_FIN) && out_valid_reg))
        else $error("result overwrote a stalled output item");
`endif

endmodule
`default_nettype wire

// ===== design/c3sb_cell.sv =====
// Window column cell: holds one 3-pixel column and forms its weighted partial sum.
`default_nettype none
module c3sb_cell
    import c3sb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    input  wire logic      col_bad,
    input  wire col_t      d_in,
    input  wire col_t      alt,
    input  wire coef_t     coef_top,
    input  wire coef_t     coef_mid,
    input  wire coef_t     coef_bot,
    output col_t           q_out,
    output psum_t          psum
);

    col_t  col_reg;
    psum_t psum_reg;
    col_t  src;
    pix_t  t_px;
    pix_t  b_px;
    psum_t sum_next;

    always_comb
    begin
        src = (col_bad && ctl.replicate) ? alt : col_reg;
        if (ctl.top_bad)
        begin
            t_px = ctl.replicate ? src.mid : '0;
        end
        else
        begin
            t_px = src.top;
        end
        if (ctl.bot_bad)
        begin
            b_px = ctl.replicate ? src.mid : '0;
        end
        else
        begin
            b_px = src.bot;
        end
        sum_next = 18'(($signed({1'b0, t_px}) * coef_top))
                 + 18'(($signed({1'b0, src.mid}) * coef_mid))
                 + 18'(($signed({1'b0, b_px}) * coef_bot));
        if (col_bad && !ctl.replicate)
        begin
            sum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (ctl.shift)
        begin
            col_reg <= d_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.calc)
        begin
            psum_reg <= sum_next;
        end
    end

    assign q_out = col_reg;
    assign psum  = psum_reg;

endmodule
`default_nettype wire
